// ===== src/adc_scan_smoothing_sequencer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ADC scan smoothing sequencer.
// Concurrent assertions clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ADC_SCAN_SMOOTHING_SEQUENCER_UNIT_MACROS_SVH
`define ADC_SCAN_SMOOTHING_SEQUENCER_UNIT_MACROS_SVH

// Checked only while reset is released.
`define ADCSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, during reset as well.
`define ADCSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/adcss_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC scan smoothing sequencer package
// Transaction types, sizes and the channel scan order shared by the design.
// ----------------------------------------------------------------------------
package adcss_pkg;

    localparam int NUM_CHANNELS = 9;
    localparam int ADDR_W       = $clog2(NUM_CHANNELS);
    localparam int CH_W         = 4;
    localparam int VAL_W        = 10;

    localparam logic [CH_W:0]   CH_LIM    = (CH_W + 1)'(NUM_CHANNELS);
    localparam logic [CH_W-1:0] LAST_CH   = CH_W'(NUM_CHANNELS - 1);
    localparam logic [CH_W-1:0] SKIP_FROM = CH_W'(3);
    localparam logic [CH_W-1:0] SKIP_TO   = CH_W'(6);

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_READ   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [VAL_W-1:0]  sample;
        logic [CH_W-1:0]   read_channel;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic              read_valid;
        logic [CH_W-1:0]   next_channel;
    } t_out_item;

    function automatic logic [CH_W-1:0] adcss_next_ch(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] nxt;
        if (ch < LAST_CH) begin
            nxt = (ch == SKIP_FROM) ? SKIP_TO : ch + CH_W'(1);
        end else begin
            nxt = '0;
        end
        return nxt;
    endfunction

endpackage

// ===== src/adcss_ram.sv =====
// ----------------------------------------------------------------------------
// ADC scan smoothing sequencer RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module adcss_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/adc_scan_smoothing_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// ADC scan smoothing sequencer
// Scans converter channels 0,1,2,3,6,7,8 in turn and keeps a smoothed value
// per channel, updated as (3*old + sample)/4.
//
// The input channel carries one transaction per item: either a finished
// conversion for the current channel or a read of a named channel. Every
// input transaction yields exactly one output transaction holding the read
// value, its valid flag and the channel to be converted next.
// Each accepted transaction passes the RAM read stage and then the output
// register: the RAM read is registered at the accepting edge, and the
// update goes into the output register when the read stage moves on. The
// block takes one transaction per cycle while the receiver does not stall;
// a RAM write that overlaps the read of the next transaction is forwarded.
// Reset clears the scan pointer to channel 0 and marks every stored value
// as zero through per-entry valid flags; no clearing pass is needed.
// When the receiver stalls, the output register holds its transaction, one
// more transaction waits in the RAM read stage, and then o_in_stall rises.
// ----------------------------------------------------------------------------
`include "adc_scan_smoothing_sequencer_unit_macros.svh"

module adc_scan_smoothing_sequencer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  adcss_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output adcss_pkg::t_out_item o_out
);
    import adcss_pkg::*;

    logic                    in_acc;
    logic                    s1_fire;
    logic                    in_ok;
    logic [ADDR_W-1:0]       in_addr;
    logic [CH_W-1:0]         in_next;

    logic [CH_W-1:0]         r_cur_ch;
    logic [CH_W-1:0]         n_cur_ch;

    logic                    r_s1_vld;
    t_kind                   r_s1_kind;
    logic                    r_s1_ok;
    logic [ADDR_W-1:0]       r_s1_addr;
    logic [VAL_W-1:0]        r_s1_sample;
    logic [CH_W-1:0]         r_s1_next;

    logic [NUM_CHANNELS-1:0] r_vbit;
    logic                    r_fwd_vld;
    logic [ADDR_W-1:0]       r_fwd_addr;
    logic [VAL_W-1:0]        r_fwd_data;

    logic [VAL_W-1:0]        ram_rdata;
    logic [VAL_W-1:0]        old_val;
    logic [VAL_W+1:0]        acc_sum;
    logic [VAL_W-1:0]        new_val;
    logic                    ram_we;

    logic                    r_out_vld;
    t_out_item               r_out;
    t_out_item               n_out;

    assign s1_fire    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        if (i_in.kind == KIND_READ) begin
            in_ok   = ({1'b0, i_in.read_channel} < CH_LIM);
            in_addr = i_in.read_channel[ADDR_W-1:0];
            in_next = r_cur_ch;
        end else begin
            in_ok   = ({1'b0, r_cur_ch} < CH_LIM);
            in_addr = r_cur_ch[ADDR_W-1:0];
            in_next = adcss_next_ch(r_cur_ch);
        end
        n_cur_ch = (in_acc && i_in.kind == KIND_SAMPLE) ? in_next : r_cur_ch;
    end

    adcss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (new_val),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_fwd_vld && r_fwd_addr == r_s1_addr) begin
            old_val = r_fwd_data;
        end else if (r_vbit[r_s1_addr]) begin
            old_val = ram_rdata;
        end else begin
            old_val = '0;
        end
        acc_sum = {2'b00, old_val} + {1'b0, old_val, 1'b0} + {2'b00, r_s1_sample};
        new_val = acc_sum[VAL_W+1:2];
        ram_we  = s1_fire && r_s1_kind == KIND_SAMPLE && r_s1_ok;

        n_out.read_valid   = (r_s1_kind == KIND_READ) && r_s1_ok;
        n_out.read_value   = n_out.read_valid ? old_val : '0;
        n_out.next_channel = r_s1_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_ch  <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_vbit    <= '0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_cur_ch <= n_cur_ch;
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (ram_we) begin
                r_vbit[r_s1_addr] <= 1'b1;
                r_fwd_vld         <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind   <= i_in.kind;
            r_s1_ok     <= in_ok;
            r_s1_addr   <= in_addr;
            r_s1_sample <= i_in.sample;
            r_s1_next   <= in_next;
        end
        if (ram_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= new_val;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `ADCSS_ASSERT(a_ptr_in_scan,
        ({1'b0, r_cur_ch} < CH_LIM) && !(r_cur_ch > SKIP_FROM && r_cur_ch < SKIP_TO),
        "scan pointer left the scan order")
    `ADCSS_ASSERT(a_fwd_marked, r_fwd_vld |-> r_vbit[r_fwd_addr],
        "forwarded entry not marked as written")
    `ADCSS_ASSERT(a_we_sample, ram_we |-> (r_s1_vld && r_s1_kind == KIND_SAMPLE),
        "store written by a non-sample transaction")
    `ADCSS_ASSERT(a_ptr_read_hold,
        (in_acc && i_in.kind == KIND_READ) |=> $stable(r_cur_ch),
        "scan pointer moved on a read")
    `ADCSS_ASSERT_ALWAYS(a_stall_needs_s1, o_in_stall |-> r_s1_vld,
        "input stalled with an empty read stage")

endmodule

// ===== dv/adc_scan_smoothing_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ADC scan smoothing sequencer testbench
// Drives conversion and read transactions into the sequencer and keeps its
// own model of the smoothed channel store and the scan pointer. Every output
// transaction is compared field by field with the oldest predicted result,
// under random idling on both sides, a long output hold-off and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module adc_scan_smoothing_sequencer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import adcss_pkg::*;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    logic [VAL_W-1:0] smooth_mem [NUM_CHANNELS];
    logic [CH_W-1:0]  scan_ch;
    t_out_item        pending_scan_results [$];
    int               errors = 0;
    bit               in_idle_en = 1'b1;
    bit               out_idle_en = 1'b1;
    bit               long_hold_req = 1'b0;

    adc_scan_smoothing_sequencer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [CH_W-1:0] scan_successor(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] nxt;
        if (ch == SKIP_FROM) begin
            nxt = SKIP_TO;
        end else if (ch < LAST_CH) begin
            nxt = ch + 1'b1;
        end else begin
            nxt = '0;
        end
        return nxt;
    endfunction

    task automatic predict_scan_result(input t_in_item item);
        t_out_item   res;
        int unsigned blended;
        res = '0;
        if (item.kind == KIND_SAMPLE) begin
            if (scan_ch < NUM_CHANNELS) begin
                blended = (3 * int'(smooth_mem[scan_ch]) + int'(item.sample)) / 4;
                smooth_mem[scan_ch] = blended[VAL_W-1:0];
            end
            scan_ch = scan_successor(scan_ch);
        end else if (item.read_channel < NUM_CHANNELS) begin
            res.read_value = smooth_mem[item.read_channel];
            res.read_valid = 1'b1;
        end
        res.next_channel = scan_ch;
        pending_scan_results.push_back(res);
    endtask

    task automatic send_item(input t_in_item item);
        int gap;
        gap = 0;
        if (in_idle_en && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_scan_result(item);
    endtask

    task automatic wait_for_results;
        i_in_valid <= 1'b0;
        while (pending_scan_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in_item make_sample(input logic [VAL_W-1:0] value);
        t_in_item item;
        item.kind         = KIND_SAMPLE;
        item.sample       = value;
        item.read_channel = CH_W'($urandom_range(0, 15));
        return item;
    endfunction

    function automatic t_in_item make_read(input logic [CH_W-1:0] ch);
        t_in_item item;
        item.kind         = KIND_READ;
        item.sample       = VAL_W'($urandom_range(0, 1023));
        item.read_channel = ch;
        return item;
    endfunction

    function automatic t_in_item random_item();
        int unsigned     pick;
        logic [VAL_W-1:0] value;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            value = '0;
        end else if (pick == 1) begin
            value = '1;
        end else begin
            value = VAL_W'($urandom_range(0, 1023));
        end
        if ($urandom_range(0, 99) < 55) begin
            return make_sample(value);
        end
        return make_read(CH_W'($urandom_range(0, 15)));
    endfunction

    task automatic test_directed;
        logic [VAL_W-1:0] scan_values [7];
        send_item(make_read(4'd0));
        send_item(make_read(4'd8));
        send_item(make_read(4'd9));
        send_item(make_read(4'd15));
        scan_values = '{10'h3FF, 10'h000, 10'h3FF, 10'h2AA, 10'h155, 10'h3FF, 10'h001};
        foreach (scan_values[k]) begin
            send_item(make_sample(scan_values[k]));
        end
        send_item(make_sample(10'h3FF));
        send_item(make_read(4'd0));
        send_item(make_read(4'd3));
        send_item(make_read(4'd4));
        send_item(make_read(4'd5));
        send_item(make_read(4'd6));
        send_item(make_read(4'd8));
        send_item(make_read(4'd9));
        wait_for_results();
    endtask

    task automatic test_random_traffic;
        repeat (300) send_item(random_item());
    endtask

    task automatic test_output_backpressure;
        i_in_valid    <= 1'b0;
        in_idle_en    = 1'b0;
        long_hold_req = 1'b1;
        wait (i_out_stall);
        @(posedge i_clk);
        repeat (20) send_item(random_item());
        in_idle_en = 1'b1;
    endtask

    task automatic test_drain_and_resume;
        repeat (10) send_item(random_item());
        wait_for_results();
        repeat (10) send_item(random_item());
    endtask

    task automatic test_full_rate;
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        repeat (100) send_item(random_item());
    endtask

    initial begin
        int          n;
        logic        v;
        forever begin
            if (long_hold_req) begin
                v = 1'b1;
                n = 48;
                long_hold_req = 1'b0;
            end else if (!out_idle_en) begin
                v = 1'b0;
                n = 1;
            end else if ($urandom_range(0, 2) == 0) begin
                v = 1'b1;
                n = $urandom_range(1, 10);
            end else begin
                v = 1'b0;
                n = $urandom_range(1, 10);
            end
            i_out_stall <= v;
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic report_mismatch(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_scan_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, o_out);
                errors++;
            end else begin
                exp_res = pending_scan_results.pop_front();
                if (o_out.read_value !== exp_res.read_value) begin
                    report_mismatch("read_value", exp_res.read_value, o_out.read_value);
                end
                if (o_out.read_valid !== exp_res.read_valid) begin
                    report_mismatch("read_valid", exp_res.read_valid, o_out.read_valid);
                end
                if (o_out.next_channel !== exp_res.next_channel) begin
                    report_mismatch("next_channel", exp_res.next_channel, o_out.next_channel);
                end
            end
        end
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        foreach (smooth_mem[k]) begin
            smooth_mem[k] = '0;
        end
        scan_ch = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_drain_and_resume();
        test_full_rate();
        wait_for_results();
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/adcss_pkg.sv
src/adcss_ram.sv
src/adc_scan_smoothing_sequencer_unit.sv
dv/adc_scan_smoothing_sequencer_unit_tb.sv
